>>> rtl/core/tccw_pkg.sv
// Shared constants for the text console cell writer: cell values, control
// character codes, command and register codes, and field widths.
// No dependencies.
package tccw_pkg;

    // Field widths of one transaction
    localparam int CODE_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;
    localparam int COLOUR_W = 8;

    // Cell values
    localparam logic [CELL_W-1:0]   BLANK_CELL   = 16'h0720;
    localparam logic [CELL_W-1:0]   ATTR_MASK    = 16'hFF00;
    localparam logic [CELL_W-1:0]   SPACE_CODE   = 16'h0020;
    localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h07;

    // Commands carried in tuser
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Control characters
    localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CH_RETURN    = 8'd13;

    // Configuration register index (byte address bit 2)
    localparam logic REG_TEXT_COLOUR = 1'b0;

endpackage

>>> rtl/core/text_console_cell_writer.sv
// Text console cell writer: screen memory, cursor tracking and scroll engine.
// Depends on tccw_pkg.
//
// A put-character or read-cell command enters on the slave stream and gives
// exactly one result (cursor position, cell value) on the master stream. The
// screen lives in one COLUMNS*ROWS x 16 synchronous RAM with a registered
// read. After reset a clearing pass writes the blank cell to every entry, one
// per cycle; no command is taken meanwhile. A printable character is written
// to the RAM when taken; newline, carriage return and tab only move the
// cursor. Backspace and read-cell wait on a RAM read, and backspace then
// writes the cell back as a space. When the cursor passes the start of the
// bottom row the scroll engine copies the screen one row up, reading one cell
// and writing one cell per cycle, before the result is handed off. The result
// sits in an output register, so the next command is taken while it waits.
module text_console_cell_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [0:0]  s_tuser,   // [0] command
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] cursor_position, [26:11] cell_value, rest zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int SCROLL_LIMIT = COLUMNS * (ROWS - 1);
    localparam int AW           = $clog2(CELL_COUNT);
    localparam int CW           = $clog2(CELL_COUNT + TAB_WIDTH + 1);
    localparam int COLW         = $clog2(COLUMNS);
    localparam int SW           = $clog2(3 * COLUMNS);
    localparam int TW           = $clog2(TAB_WIDTH + 1);
    localparam int CMOD         = COLUMNS % TAB_WIDTH;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_BS_WR  = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    // Screen memory
    logic [tccw_pkg::CELL_W-1:0] screen_mem [CELL_COUNT];
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [tccw_pkg::CELL_W-1:0] rdata_reg;

    // Control and cursor state
    logic [2:0]                    state_reg, state_next;
    logic [AW-1:0]                 scan_reg, scan_next;
    logic [CW-1:0]                 cursor_reg, cursor_next;
    logic [CW-1:0]                 row_base_reg, row_base_next;
    logic [COLW-1:0]               col_reg, col_next;
    logic [TW-1:0]                 tab_off_reg, tab_off_next;   // cursor mod TAB_WIDTH
    logic [TW-1:0]                 rb_off_reg, rb_off_next;     // row base mod TAB_WIDTH
    logic                          rd_hit_reg, rd_hit_next;
    logic [tccw_pkg::CELL_W-1:0]   res_value_reg, res_value_next;
    logic [tccw_pkg::COLOUR_W-1:0] colour_reg;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    logic [tccw_pkg::CURSOR_W-1:0] out_cursor_reg, out_cursor_next;
    logic [tccw_pkg::CELL_W-1:0]   out_value_reg, out_value_next;

    // Input fields
    logic                          in_command;
    logic [tccw_pkg::CODE_W-1:0]   in_code;
    logic [tccw_pkg::INDEX_W-1:0]  in_index;

    // Tab helpers
    logic [TW-1:0] tab_delta;
    logic [SW-1:0] col_sum;

    assign in_command = s_tuser[0];
    assign in_code    = s_tdata[7:0];
    assign in_index   = s_tdata[18:8];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_value_reg, out_cursor_reg};

    // Offset arithmetic modulo TAB_WIDTH when moving by one row
    function automatic logic [TW-1:0] off_add(input logic [TW-1:0] x);
        logic [TW:0] s;
        s = {1'b0, x} + (TW+1)'(CMOD);
        if (s >= (TW+1)'(TAB_WIDTH))
        begin
            s = s - (TW+1)'(TAB_WIDTH);
        end
        return s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] off_sub(input logic [TW-1:0] x);
        logic [TW:0] s;
        if ({1'b0, x} >= (TW+1)'(CMOD))
        begin
            s = {1'b0, x} - (TW+1)'(CMOD);
        end
        else
        begin
            s = {1'b0, x} + (TW+1)'(TAB_WIDTH) - (TW+1)'(CMOD);
        end
        return s[TW-1:0];
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        cursor_next     = cursor_reg;
        row_base_next   = row_base_reg;
        col_next        = col_reg;
        tab_off_next    = tab_off_reg;
        rb_off_next     = rb_off_reg;
        rd_hit_next     = rd_hit_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        out_cursor_next = out_cursor_reg;
        out_value_next  = out_value_reg;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = tccw_pkg::BLANK_CELL;
        mem_re          = 1'b0;
        mem_raddr       = scan_reg;
        tab_delta       = TW'(TAB_WIDTH) - tab_off_reg;
        col_sum         = SW'(col_reg) + SW'(tab_delta);

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = tccw_pkg::BLANK_CELL;
                if (scan_reg == AW'(CELL_COUNT - 1))
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_value_next = '0;
                    if (in_command == tccw_pkg::CMD_READ)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(in_index);
                        rd_hit_next = (32'(in_index) < CELL_COUNT);
                        state_next  = ST_RD;
                    end
                    else
                    begin
                        case (in_code)
                            tccw_pkg::CH_BACKSPACE:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_next = cursor_reg - 1'b1;
                                    mem_re      = 1'b1;
                                    mem_raddr   = AW'(cursor_reg - 1'b1);
                                    if (col_reg == '0)
                                    begin
                                        col_next      = COLW'(COLUMNS - 1);
                                        row_base_next = row_base_reg - CW'(COLUMNS);
                                        rb_off_next   = off_sub(rb_off_reg);
                                    end
                                    else
                                    begin
                                        col_next = col_reg - 1'b1;
                                    end
                                    if (tab_off_reg == '0)
                                    begin
                                        tab_off_next = TW'(TAB_WIDTH - 1);
                                    end
                                    else
                                    begin
                                        tab_off_next = tab_off_reg - 1'b1;
                                    end
                                end
                            end
                            tccw_pkg::CH_NEWLINE:
                            begin
                                cursor_next   = row_base_reg + CW'(COLUMNS);
                                row_base_next = row_base_reg + CW'(COLUMNS);
                                col_next      = '0;
                                rb_off_next   = off_add(rb_off_reg);
                                tab_off_next  = off_add(rb_off_reg);
                            end
                            tccw_pkg::CH_RETURN:
                            begin
                                cursor_next  = row_base_reg;
                                col_next     = '0;
                                tab_off_next = rb_off_reg;
                            end
                            tccw_pkg::CH_TAB:
                            begin
                                cursor_next  = cursor_reg + CW'(tab_delta);
                                tab_off_next = '0;
                                // a tab may cross up to two row boundaries on narrow screens
                                if (col_sum >= SW'(2 * COLUMNS))
                                begin
                                    col_next      = COLW'(col_sum - SW'(2 * COLUMNS));
                                    row_base_next = row_base_reg + CW'(2 * COLUMNS);
                                    rb_off_next   = off_add(off_add(rb_off_reg));
                                end
                                else if (col_sum >= SW'(COLUMNS))
                                begin
                                    col_next      = COLW'(col_sum - SW'(COLUMNS));
                                    row_base_next = row_base_reg + CW'(COLUMNS);
                                    rb_off_next   = off_add(rb_off_reg);
                                end
                                else
                                begin
                                    col_next = COLW'(col_sum);
                                end
                            end
                            default:
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = AW'(cursor_reg);
                                mem_wdata   = {colour_reg, in_code};
                                cursor_next = cursor_reg + 1'b1;
                                if (col_reg == COLW'(COLUMNS - 1))
                                begin
                                    col_next      = '0;
                                    row_base_next = row_base_reg + CW'(COLUMNS);
                                    rb_off_next   = off_add(rb_off_reg);
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                                if (tab_off_reg == TW'(TAB_WIDTH - 1))
                                begin
                                    tab_off_next = '0;
                                end
                                else
                                begin
                                    tab_off_next = tab_off_reg + 1'b1;
                                end
                            end
                        endcase
                        scan_next = '0;
                        if ((in_code == tccw_pkg::CH_BACKSPACE) && (cursor_reg != '0))
                        begin
                            state_next = ST_BS_WR;
                        end
                        else if (cursor_next > CW'(SCROLL_LIMIT))
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_BS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(cursor_reg);
                mem_wdata  = (rdata_reg & tccw_pkg::ATTR_MASK) | tccw_pkg::SPACE_CODE;
                state_next = ST_DONE;
            end

            ST_RD:
            begin
                res_value_next = rd_hit_reg ? rdata_reg : '0;
                state_next     = ST_DONE;
            end

            ST_SCROLL:
            begin
                // read one row ahead, write the cell read in the previous cycle
                if (scan_reg < AW'(SCROLL_LIMIT))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = scan_reg + AW'(COLUMNS);
                end
                if (scan_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = scan_reg - 1'b1;
                    mem_wdata = rdata_reg;
                end
                if (scan_reg == AW'(SCROLL_LIMIT))
                begin
                    scan_next     = '0;
                    cursor_next   = cursor_reg - CW'(COLUMNS);
                    row_base_next = row_base_reg - CW'(COLUMNS);
                    tab_off_next  = off_sub(tab_off_reg);
                    rb_off_next   = off_sub(rb_off_reg);
                    if (cursor_next > CW'(SCROLL_LIMIT))
                    begin
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_cursor_next = tccw_pkg::CURSOR_W'(cursor_reg);
                    out_value_next  = res_value_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            scan_reg     <= '0;
            cursor_reg   <= '0;
            row_base_reg <= '0;
            col_reg      <= '0;
            tab_off_reg  <= '0;
            rb_off_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            cursor_reg   <= cursor_next;
            row_base_reg <= row_base_next;
            col_reg      <= col_next;
            tab_off_reg  <= tab_off_next;
            rb_off_reg   <= rb_off_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_hit_reg     <= rd_hit_next;
        res_value_reg  <= res_value_next;
        out_cursor_reg <= out_cursor_next;
        out_value_reg  <= out_value_next;
    end

    // Screen RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= tccw_pkg::RESET_COLOUR;
        end
        else if (psel && penable && pwrite && (paddr[2] == tccw_pkg::REG_TEXT_COLOUR))
        begin
            colour_reg <= pwdata[tccw_pkg::COLOUR_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == tccw_pkg::REG_TEXT_COLOUR)
        begin
            prdata = {24'd0, colour_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Checks
    a_cursor_split: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg == row_base_reg + CW'(col_reg)) && (col_reg < COLW'(COLUMNS)))
        else $error("cursor does not match row base plus column");

    a_idle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cursor_reg <= CW'(SCROLL_LIMIT)))
        else $error("cursor past scroll limit while idle");

    a_scroll_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) |-> (cursor_reg > CW'(SCROLL_LIMIT)))
        else $error("scroll pass running with cursor in range");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!m_valid_reg || m_tready)) |=>
        (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not handed to output register");

endmodule
